// ===== sv/rtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtr_pkg - retargetable time ramp shared definitions
// Number formats, command codes and the microcode store of the sequencer.
// ----------------------------------------------------------------------------
package rtr_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int VALUE_WIDTH   = 32;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int TIME_W        = 31;
	localparam int UPC_W         = 5;
	localparam int CNT_W         = 5;

	localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRACTION_BITS;

	// command codes of an input beat
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_SET_TARGET = 3'd1;
	localparam logic [2:0] CMD_SET_BLEND  = 3'd2;
	localparam logic [2:0] CMD_SET_ALPHA  = 3'd3;
	localparam logic [2:0] CMD_RESTART    = 3'd4;

	// datapath actions, one per control word
	typedef enum logic [4:0] {
		MU_NOP,
		MU_RA_DIFF,
		MU_RA_ABS,
		MU_RA_CMP,
		MU_DIV_ITER,
		MU_APPLY_MUL,
		MU_APPLY_SET,
		MU_RT_MUL,
		MU_RT_SET,
		MU_TK_MUL,
		MU_TK_DSET,
		MU_TK_ADD,
		MU_DONE,
		MU_FINISH,
		MU_SET_TARGET,
		MU_SET_BLEND,
		MU_SET_ALPHA,
		MU_RESTART
	} mu_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NO_REALIGN,
		JC_NO_RETIME,
		JC_RAMP_ZERO,
		JC_NO_RUN,
		JC_SKIP,
		JC_DIV_MORE
	} jump_cond_t;

	typedef struct packed {
		mu_op_t           op;
		jump_cond_t       cond;
		logic [UPC_W-1:0] target;
	} ctrl_word_t;

	// entry points
	localparam logic [UPC_W-1:0] UA_TICK      = 5'd0;
	localparam logic [UPC_W-1:0] UA_RETIME    = 5'd7;
	localparam logic [UPC_W-1:0] UA_RT_ZERO   = 5'd10;
	localparam logic [UPC_W-1:0] UA_TK_BODY   = 5'd11;
	localparam logic [UPC_W-1:0] UA_TK_DONE   = 5'd17;
	localparam logic [UPC_W-1:0] UA_FINISH    = 5'd18;
	localparam logic [UPC_W-1:0] UA_TARGET    = 5'd19;
	localparam logic [UPC_W-1:0] UA_BLEND     = 5'd20;
	localparam logic [UPC_W-1:0] UA_ALPHA     = 5'd21;
	localparam logic [UPC_W-1:0] UA_AL_APPLY  = 5'd22;
	localparam logic [UPC_W-1:0] UA_RESTART   = 5'd24;
	localparam logic [UPC_W-1:0] UA_RA_APPLY  = 5'd5;
	localparam logic [UPC_W-1:0] UA_RA_DIV    = 5'd4;
	localparam logic [UPC_W-1:0] UA_TK_DIV    = 5'd13;

	function automatic ctrl_word_t cw(mu_op_t op, jump_cond_t cond, logic [UPC_W-1:0] target);
		ctrl_word_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// microcode store
	function automatic ctrl_word_t ucode(logic [UPC_W-1:0] upc);
		ctrl_word_t w;
		case (upc)
			// tick: realignment
			5'd0:  w = cw(MU_NOP,        JC_NO_REALIGN, UA_RETIME);
			5'd1:  w = cw(MU_RA_DIFF,    JC_NEXT,       UA_FINISH);
			5'd2:  w = cw(MU_RA_ABS,     JC_NEXT,       UA_FINISH);
			5'd3:  w = cw(MU_RA_CMP,     JC_SKIP,       UA_RA_APPLY);
			5'd4:  w = cw(MU_DIV_ITER,   JC_DIV_MORE,   UA_RA_DIV);
			5'd5:  w = cw(MU_APPLY_MUL,  JC_NEXT,       UA_FINISH);
			5'd6:  w = cw(MU_APPLY_SET,  JC_NEXT,       UA_FINISH);
			// tick: retiming
			5'd7:  w = cw(MU_NOP,        JC_NO_RETIME,  UA_TK_BODY);
			5'd8:  w = cw(MU_RT_MUL,     JC_RAMP_ZERO,  UA_RT_ZERO);
			5'd9:  w = cw(MU_RT_SET,     JC_ALWAYS,     UA_TK_BODY);
			5'd10: w = cw(MU_DONE,       JC_NEXT,       UA_FINISH);
			// tick: advance
			5'd11: w = cw(MU_TK_MUL,     JC_NO_RUN,     UA_TK_DONE);
			5'd12: w = cw(MU_TK_DSET,    JC_NEXT,       UA_FINISH);
			5'd13: w = cw(MU_DIV_ITER,   JC_DIV_MORE,   UA_TK_DIV);
			5'd14: w = cw(MU_TK_ADD,     JC_NEXT,       UA_FINISH);
			5'd15: w = cw(MU_APPLY_MUL,  JC_NEXT,       UA_FINISH);
			5'd16: w = cw(MU_APPLY_SET,  JC_ALWAYS,     UA_FINISH);
			5'd17: w = cw(MU_DONE,       JC_NEXT,       UA_FINISH);
			5'd18: w = cw(MU_FINISH,     JC_NEXT,       UA_FINISH);
			// other commands
			5'd19: w = cw(MU_SET_TARGET, JC_ALWAYS,     UA_FINISH);
			5'd20: w = cw(MU_SET_BLEND,  JC_ALWAYS,     UA_FINISH);
			5'd21: w = cw(MU_SET_ALPHA,  JC_NEXT,       UA_FINISH);
			5'd22: w = cw(MU_APPLY_MUL,  JC_NEXT,       UA_FINISH);
			5'd23: w = cw(MU_APPLY_SET,  JC_ALWAYS,     UA_FINISH);
			5'd24: w = cw(MU_RESTART,    JC_ALWAYS,     UA_AL_APPLY);
			default: w = cw(MU_FINISH,   JC_NEXT,       UA_FINISH);
		endcase
		return w;
	endfunction

	// entry address per command
	function automatic logic [UPC_W-1:0] dispatch(logic [2:0] cmd);
		logic [UPC_W-1:0] a;
		case (cmd)
			CMD_TICK:       a = UA_TICK;
			CMD_SET_TARGET: a = UA_TARGET;
			CMD_SET_BLEND:  a = UA_BLEND;
			CMD_SET_ALPHA:  a = UA_ALPHA;
			CMD_RESTART:    a = UA_RESTART;
			default:        a = UA_FINISH;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/retargetable_time_ramp.sv =====
`timescale 1ns / 1ps
// Throughput: one beat at a time; the next beat is taken in the cycle after the result
//   is loaded into the output register, which holds it while out_stall is high.
// Reset: arst_n clears the ramp to its complete state (value one, alpha one, no time
//   left, nothing pending) and empties the output register.
// ----------------------------------------------------------------------------
// retargetable_time_ramp - time-driven linear blend toward a movable target
// A microcoded sequencer steps a datapath with one shared multiplier and one
// shared restoring divider, a bit per cycle.
// ----------------------------------------------------------------------------
module retargetable_time_ramp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic signed [31:0] alpha_request,
	input  logic signed [31:0] duration,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] blended_value,
	output logic [16:0]        blend_fraction,
	output logic [30:0]        time_left,
	output logic               settled
);

	localparam int FB  = rtr_pkg::FRACTION_BITS;
	localparam int FW  = rtr_pkg::FRAC_W;
	localparam int VW  = rtr_pkg::VALUE_WIDTH;
	localparam int TW  = rtr_pkg::TIME_W;
	localparam int UW  = rtr_pkg::UPC_W;
	localparam int CW  = rtr_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	logic [UW-1:0] upc_q;
	rtr_pkg::ctrl_word_t cw;

	// ramp state
	logic signed [VW-1:0] start_q, goal_q, cur_q;
	logic [FW-1:0]        frac_q;
	logic [TW-1:0]        ticks_q, ramp_q;
	logic                 realign_q, retime_q;

	// latched beat
	logic signed [VW-1:0] value_q;
	logic signed [31:0]   alpha_q;
	logic [TW-1:0]        dt_q;

	// working registers
	logic signed [VW:0]   num_q, den_q;
	logic [FW-1:0]        afrac_q;    // fraction to apply, also divider quotient
	logic signed [50:0]   prod_q;
	logic [31:0]          rem_q, dvs_q;
	logic [FW-1:0]        dvd_q;      // dividend bits still to shift in
	logic [CW-1:0]        cnt_q;
	logic                 skip_q;

	// shared multiplier
	logic signed [VW:0]   mul_a;
	logic signed [FW:0]   mul_b;
	logic signed [50:0]   mul_p;
	logic signed [VW:0]   diff;
	logic [FW-1:0]        frac_rest;

	// divider step
	logic [32:0]          div_t;
	logic                 div_ge;
	logic [31:0]          div_r;

	logic                 rem_ge;
	logic                 jump;
	logic                 advance;
	logic                 in_take;
	logic [VW:0]          num_abs, den_abs;
	logic [FW-1:0]        alpha_clamped;
	logic                 out_valid_q;

	assign cw        = rtr_pkg::ucode(upc_q);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	assign diff      = {goal_q[VW-1], goal_q} - {start_q[VW-1], start_q};
	assign frac_rest = rtr_pkg::ONE - frac_q;

	always_comb begin
		case (cw.op)
			rtr_pkg::MU_APPLY_MUL: begin
				mul_a = diff;
				mul_b = {1'b0, afrac_q};
			end
			rtr_pkg::MU_RT_MUL: begin
				mul_a = {{(VW+1-TW){1'b0}}, ramp_q};
				mul_b = {1'b0, frac_rest};
			end
			rtr_pkg::MU_TK_MUL: begin
				mul_a = {{(VW+1-TW){1'b0}}, dt_q};
				mul_b = {1'b0, frac_rest};
			end
			default: begin
				mul_a = {{(VW+1-TW){1'b0}}, dt_q};
				mul_b = {1'b0, frac_rest};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign div_t  = {rem_q, dvd_q[FW-1]};
	assign div_ge = (div_t >= {1'b0, dvs_q});
	assign div_r  = div_ge ? 32'(div_t - {1'b0, dvs_q}) : div_t[31:0];
	assign rem_ge = (rem_q >= dvs_q);

	assign num_abs = num_q[VW] ? (VW+1)'(-num_q) : num_q;
	assign den_abs = den_q[VW] ? (VW+1)'(-den_q) : den_q;

	always_comb begin
		if (alpha_q[31])
			alpha_clamped = '0;
		else if (alpha_q > $signed({15'd0, rtr_pkg::ONE}))
			alpha_clamped = rtr_pkg::ONE;
		else
			alpha_clamped = alpha_q[FW-1:0];
	end

	always_comb begin
		case (cw.cond)
			rtr_pkg::JC_NEXT:       jump = 1'b0;
			rtr_pkg::JC_ALWAYS:     jump = 1'b1;
			rtr_pkg::JC_NO_REALIGN: jump = !realign_q;
			rtr_pkg::JC_NO_RETIME:  jump = !retime_q;
			rtr_pkg::JC_RAMP_ZERO:  jump = (ramp_q == '0);
			rtr_pkg::JC_NO_RUN:     jump = !(ticks_q > dt_q);
			rtr_pkg::JC_SKIP:       jump = skip_q || rem_ge;
			rtr_pkg::JC_DIV_MORE:   jump = (cnt_q != CW'(1));
			default:                jump = 1'b0;
		endcase
	end

	// the finish step waits while the output register is full and out_stall is high
	assign advance = !(cw.op == rtr_pkg::MU_FINISH && out_valid_q && out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			upc_q   <= rtr_pkg::UA_FINISH;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_RUN;
						upc_q   <= rtr_pkg::dispatch(command);
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (cw.op == rtr_pkg::MU_FINISH)
							state_q <= ST_IDLE;
						else if (jump)
							upc_q <= cw.target;
						else
							upc_q <= upc_q + UW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// beat latch
	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= value;
			alpha_q <= alpha_request;
			dt_q    <= duration[31] ? '0 : duration[TW-1:0];
		end
	end

	// ramp state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			goal_q    <= VW'(rtr_pkg::ONE);
			cur_q     <= VW'(rtr_pkg::ONE);
			frac_q    <= rtr_pkg::ONE;
			ticks_q   <= '0;
			ramp_q    <= '0;
			realign_q <= 1'b0;
			retime_q  <= 1'b0;
			skip_q    <= 1'b0;
			cnt_q     <= '0;
			num_q     <= '0;
			den_q     <= '0;
			afrac_q   <= '0;
			prod_q    <= '0;
			rem_q     <= '0;
			dvs_q     <= '0;
			dvd_q     <= '0;
		end else if (state_q == ST_RUN) begin
			case (cw.op)
				rtr_pkg::MU_RA_DIFF: begin
					num_q     <= {cur_q[VW-1], cur_q} - {start_q[VW-1], start_q};
					den_q     <= diff;
					realign_q <= 1'b0;
				end
				rtr_pkg::MU_RA_ABS: begin
					rem_q <= num_abs[31:0];
					dvs_q <= den_abs[31:0];
					if (den_q == '0) begin
						afrac_q <= rtr_pkg::ONE;
						skip_q  <= 1'b1;
					end else if (num_q == '0 || (num_q[VW] != den_q[VW])) begin
						afrac_q <= '0;
						skip_q  <= 1'b1;
					end else begin
						skip_q  <= 1'b0;
					end
				end
				rtr_pkg::MU_RA_CMP: begin
					if (!skip_q) begin
						if (rem_ge) begin
							afrac_q <= rtr_pkg::ONE;
						end else begin
							afrac_q <= '0;
							dvd_q   <= '0;
							cnt_q   <= CW'(FB);
						end
					end
				end
				rtr_pkg::MU_DIV_ITER: begin
					rem_q   <= div_r;
					dvd_q   <= {dvd_q[FW-2:0], 1'b0};
					afrac_q <= {afrac_q[FW-2:0], div_ge};
					cnt_q   <= cnt_q - CW'(1);
				end
				rtr_pkg::MU_APPLY_MUL: begin
					frac_q <= afrac_q;
					prod_q <= mul_p;
				end
				rtr_pkg::MU_APPLY_SET: begin
					if (frac_q == rtr_pkg::ONE)
						cur_q <= goal_q;
					else
						cur_q <= start_q + $signed(prod_q[FB +: VW]);
				end
				rtr_pkg::MU_RT_MUL: begin
					prod_q   <= mul_p;
					retime_q <= 1'b0;
				end
				rtr_pkg::MU_RT_SET: begin
					ticks_q <= prod_q[FB +: TW];
				end
				rtr_pkg::MU_TK_MUL: begin
					prod_q <= mul_p;
				end
				rtr_pkg::MU_TK_DSET: begin
					// quotient stays below one, so the top part is already below ticks
					rem_q   <= {1'b0, prod_q[FW +: TW]};
					dvd_q   <= prod_q[FW-1:0];
					dvs_q   <= {1'b0, ticks_q};
					cnt_q   <= CW'(FW);
					afrac_q <= '0;
					ticks_q <= ticks_q - dt_q;
				end
				rtr_pkg::MU_TK_ADD: begin
					afrac_q <= frac_q + afrac_q;
				end
				rtr_pkg::MU_DONE: begin
					ticks_q <= '0;
					frac_q  <= rtr_pkg::ONE;
					cur_q   <= goal_q;
				end
				rtr_pkg::MU_SET_TARGET: begin
					start_q   <= cur_q;
					goal_q    <= value_q;
					realign_q <= 1'b1;
				end
				rtr_pkg::MU_SET_BLEND: begin
					ramp_q   <= dt_q;
					retime_q <= 1'b1;
				end
				rtr_pkg::MU_SET_ALPHA: begin
					afrac_q <= alpha_clamped;
				end
				rtr_pkg::MU_RESTART: begin
					realign_q <= 1'b0;
					retime_q  <= 1'b0;
					if (ramp_q == '0) begin
						afrac_q <= rtr_pkg::ONE;
						ticks_q <= '0;
					end else begin
						afrac_q <= '0;
						ticks_q <= ramp_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RUN && cw.op == rtr_pkg::MU_FINISH && advance)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && cw.op == rtr_pkg::MU_FINISH && advance) begin
			blended_value  <= cur_q;
			blend_fraction <= frac_q;
			time_left      <= ticks_q;
			settled        <= (ticks_q == '0) && (frac_q == rtr_pkg::ONE);
		end
	end

endmodule
